[src/hcbp_pkg.sv]
// Shared types and constants for the Huffman code bit packer.
// Used by the controller, the datapath, the top level and the port checker.
package hcbp_pkg;

   localparam int CODE_W = 32;
   localparam int LEN_W  = 6;
   localparam int SYM_W  = 8;
   localparam int BYTE_W = 8;
   localparam int POS_W  = 3;

   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_ENCODE = 2'd1,
      CMD_FLUSH  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [SYM_W-1:0]  symbol;
      logic [CODE_W-1:0] code_word;
      logic [LEN_W-1:0]  code_length;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] packed_byte;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  len;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ALIGN,
      ST_PACK
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic mem_write;
      logic mem_read;
      logic flush;
      logic align;
      logic step;
   } ctrl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic sym_ok;
      logic rem_zero;
      logic final_step;
   } stat_type;

endpackage

[src/huffman_code_bit_packer.sv]
// Top level of the Huffman code bit packer.
// Depends on hcbp_pkg, hcbp_ctrl and hcbp_datapath.
//
// Usage: a word on req_item is accepted at a rising edge where start is high
// and busy is low. A load command writes one symbol's code word and length
// into the code table and produces no result. An encode command looks the
// symbol up and appends its code bits, most significant first, to a byte
// that fills from bit 7 down; each completed byte leaves on rsp_item with
// rsp_strobe high for one cycle. A flush command always emits the pending
// byte, zero padded, and clears the accumulator.
// Every result word is registered and appears the cycle after the edge that
// produced it. The last word caused by a command carries last set.
// Load and flush leave busy low, so they can be issued back to back. An
// encode reads the table on its accepting edge, then keeps busy high for
// one alignment of the code word, then one step of the packing unit per
// cycle, at most five packing steps in all: one per byte completed, plus a
// final partial one if bits are left over. A zero-length code still passes
// through the packing state. The next word is accepted once busy falls.
// Reset empties the accumulator and returns to idle; the code table is not
// cleared, and encoding a symbol that was never loaded is not allowed.
// The receiver cannot hold results off, so no result is ever stalled.
module huffman_code_bit_packer #(
   parameter int SYMBOL_COUNT = 256,
   parameter int MAX_CODE_LEN = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  hcbp_pkg::req_type req_item,
   output logic              rsp_strobe,
   output hcbp_pkg::rsp_type rsp_item
);

   hcbp_pkg::ctrl_type ctrl;
   hcbp_pkg::stat_type stat;

   // The controller sequences the table read, the alignment and the packing steps.
   hcbp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .cmd   (req_item.cmd),
      .stat  (stat),
      .ctrl  (ctrl),
      .busy  (busy)
   );

   // The datapath owns the table, the accumulator and the result register.
   hcbp_datapath #(
      .SYMBOL_COUNT (SYMBOL_COUNT),
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .ctrl       (ctrl),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

[src/hcbp_ctrl.sv]
// Controller state machine of the Huffman code bit packer.
// Depends on hcbp_pkg; drives the datapath through ctrl_type commands.
module hcbp_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  hcbp_pkg::cmd_type  cmd,
   input  hcbp_pkg::stat_type stat,
   output hcbp_pkg::ctrl_type ctrl,
   output logic               busy
);

   hcbp_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hcbp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hcbp_pkg::ST_IDLE: begin
            if (start && cmd == hcbp_pkg::CMD_ENCODE && stat.sym_ok) begin
               state_in = hcbp_pkg::ST_ALIGN;
            end
         end
         hcbp_pkg::ST_ALIGN: begin
            state_in = hcbp_pkg::ST_PACK;
         end
         hcbp_pkg::ST_PACK: begin
            if (stat.rem_zero || stat.final_step) begin
               state_in = hcbp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hcbp_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl = '0;
      busy = 1'b1;
      unique case (state_ff)
         hcbp_pkg::ST_IDLE: begin
            busy           = 1'b0;
            ctrl.mem_write = start && cmd == hcbp_pkg::CMD_LOAD && stat.sym_ok;
            ctrl.mem_read  = start && cmd == hcbp_pkg::CMD_ENCODE && stat.sym_ok;
            ctrl.flush     = start && cmd == hcbp_pkg::CMD_FLUSH;
         end
         hcbp_pkg::ST_ALIGN: begin
            ctrl.align = 1'b1;
         end
         hcbp_pkg::ST_PACK: begin
            ctrl.step = !stat.rem_zero;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

[src/hcbp_datapath.sv]
// Datapath of the Huffman code bit packer: code table, bit accumulator, result register.
// Depends on hcbp_pkg; steered by hcbp_ctrl.
module hcbp_datapath #(
   parameter int SYMBOL_COUNT = 256,
   parameter int MAX_CODE_LEN = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  hcbp_pkg::req_type  req_item,
   input  hcbp_pkg::ctrl_type ctrl,
   output hcbp_pkg::stat_type stat,
   output logic               rsp_strobe,
   output hcbp_pkg::rsp_type  rsp_item
);

   localparam int AW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
   localparam int LenLim = (MAX_CODE_LEN < hcbp_pkg::CODE_W) ? MAX_CODE_LEN
                                                             : hcbp_pkg::CODE_W;

   hcbp_pkg::entry_type mem [SYMBOL_COUNT];
   hcbp_pkg::entry_type rd_ff;

   logic [hcbp_pkg::CODE_W-1:0] code_ff, code_in;
   logic [hcbp_pkg::LEN_W-1:0]  rem_ff, rem_in;
   logic [hcbp_pkg::BYTE_W-1:0] acc_ff, acc_in;
   logic [hcbp_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   hcbp_pkg::rsp_type           rsp_ff, rsp_in;

   logic [AW-1:0]               addr;
   logic [hcbp_pkg::LEN_W-1:0]  len_sat;
   logic [hcbp_pkg::LEN_W-1:0]  avail;
   logic [hcbp_pkg::LEN_W-1:0]  take;
   logic [hcbp_pkg::LEN_W-1:0]  rem_next;
   logic [hcbp_pkg::BYTE_W-1:0] acc_new;
   logic                        full;

   assign addr    = req_item.symbol[AW-1:0];
   assign len_sat = (req_item.code_length > hcbp_pkg::LEN_W'(LenLim))
                    ? hcbp_pkg::LEN_W'(LenLim) : req_item.code_length;

   assign stat.sym_ok = ({1'b0, req_item.symbol} < (hcbp_pkg::SYM_W + 1)'(SYMBOL_COUNT));

   // The table is written on a load, and read in the cycle before alignment.
   always_ff @(posedge clock) begin
      if (ctrl.mem_write) begin
         mem[addr] <= '{code: req_item.code_word, len: len_sat};
      end
      if (ctrl.mem_read) begin
         rd_ff <= mem[addr];
      end
   end

   // One step moves as many code bits as the byte has room for, or all if fewer.
   assign avail    = hcbp_pkg::LEN_W'({1'b0, pos_ff}) + hcbp_pkg::LEN_W'(1);
   assign take     = (rem_ff < avail) ? rem_ff : avail;
   assign full     = (take == avail);
   assign rem_next = rem_ff - take;
   assign acc_new  = acc_ff | (code_ff[hcbp_pkg::CODE_W-1 -: hcbp_pkg::BYTE_W]
                               >> (hcbp_pkg::POS_W'(7) - pos_ff));

   assign stat.rem_zero   = (rem_ff == '0);
   assign stat.final_step = (rem_next == '0);

   always_comb begin
      code_in      = code_ff;
      rem_in       = rem_ff;
      acc_in       = acc_ff;
      pos_in       = pos_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      priority if (ctrl.align) begin
         // Left align the code so that its first bit sits at the top.
         code_in = rd_ff.code << (hcbp_pkg::LEN_W'(hcbp_pkg::CODE_W) - rd_ff.len);
         rem_in  = rd_ff.len;
      end else if (ctrl.step) begin
         code_in = code_ff << take;
         rem_in  = rem_next;
         if (full) begin
            rsp_valid_in       = 1'b1;
            rsp_in.packed_byte = acc_new;
            // Fewer than eight bits left cannot fill another byte.
            rsp_in.last        = (rem_next[hcbp_pkg::LEN_W-1:hcbp_pkg::POS_W] == '0);
            acc_in             = '0;
            pos_in             = hcbp_pkg::POS_W'(7);
         end else begin
            acc_in = acc_new;
            pos_in = pos_ff - take[hcbp_pkg::POS_W-1:0];
         end
      end else if (ctrl.flush) begin
         rsp_valid_in       = 1'b1;
         rsp_in.packed_byte = acc_ff;
         rsp_in.last        = 1'b1;
         acc_in             = '0;
         pos_in             = hcbp_pkg::POS_W'(7);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         pos_ff       <= hcbp_pkg::POS_W'(7);
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
      rem_ff  <= rem_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

endmodule

[src/hcbp_checker.sv]
// Port-level checker for the Huffman code bit packer, bound to the top level.
// Depends on hcbp_pkg.
module hcbp_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input hcbp_pkg::req_type req_item,
   input logic              rsp_strobe,
   input hcbp_pkg::rsp_type rsp_item
);

   logic accept;
   assign accept = start && !busy;

   // A flush always yields exactly one word, marked last, on the next cycle.
   a_flush_emits: assert property (@(posedge clock) disable iff (reset)
      accept && req_item.cmd == hcbp_pkg::CMD_FLUSH |=> rsp_strobe && rsp_item.last)
      else $error("flush did not emit a last word");

   // A load never produces a result word.
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      accept && req_item.cmd == hcbp_pkg::CMD_LOAD |=> !rsp_strobe)
      else $error("load produced a result word");

   // A word that is not last means the encode is still in progress.
   a_more_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.last |-> busy)
      else $error("non-last word while idle");

   // Reset leaves the block idle with no result pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !busy && !rsp_strobe)
      else $error("block not idle after reset");

endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_item   (req_item),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);

[test/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for huffman_code_bit_packer: loads code tables, encodes
// symbols and flushes, predicting every packed byte. Depends on hcbp_pkg and the RTL.
module tb_top;

   // Same table limits as the instance below.
   localparam int MAX_CODE_LEN = 32;
   localparam int LEN_LIMIT    = (MAX_CODE_LEN < hcbp_pkg::CODE_W) ? MAX_CODE_LEN
                                                                   : hcbp_pkg::CODE_W;
   // Longest run of cycles in which neither a command nor a byte moves.
   localparam int STALL_LIMIT  = 500;

   // Tracks the code table and the byte accumulator, and holds the bytes that
   // the block still owes us, oldest first.
   class packed_byte_tracker;
      hcbp_pkg::entry_type code_table [256];
      logic [7:0]          acc_byte;
      logic [2:0]          fill_pos;
      hcbp_pkg::rsp_type   owed_bytes [$];
      int                  errors, bytes_seen, loads, encodes, flushes, ignored;

      function new();
         acc_byte = '0;
         fill_pos = 3'd7;
         foreach (code_table[i]) code_table[i] = '0;
      endfunction

      // Called for every word the block accepts.
      function void note_word(hcbp_pkg::req_type w);
         hcbp_pkg::entry_type e;
         int                  total, made;
         hcbp_pkg::rsp_type   r;
         case (w.cmd)
            hcbp_pkg::CMD_LOAD: begin
               loads++;
               e.code = w.code_word;
               e.len  = (w.code_length > LEN_LIMIT) ? hcbp_pkg::LEN_W'(LEN_LIMIT)
                                                    : w.code_length;
               code_table[w.symbol] = e;
            end
            hcbp_pkg::CMD_ENCODE: begin
               encodes++;
               e = code_table[w.symbol];
               // Bytes completed by this symbol, so the final one can carry last.
               total = (7 - int'(fill_pos) + int'(e.len)) / 8;
               made  = 0;
               for (int i = int'(e.len); i > 0; i--) begin
                  if (e.code[i-1]) acc_byte[fill_pos] = 1'b1;
                  if (fill_pos == 3'd0) begin
                     r.packed_byte = acc_byte;
                     r.last        = (made == total - 1);
                     owed_bytes.push_back(r);
                     made++;
                     acc_byte = '0;
                     fill_pos = 3'd7;
                  end else begin
                     fill_pos--;
                  end
               end
            end
            hcbp_pkg::CMD_FLUSH: begin
               flushes++;
               r.packed_byte = acc_byte;
               r.last        = 1'b1;
               owed_bytes.push_back(r);
               acc_byte = '0;
               fill_pos = 3'd7;
            end
            default: ignored++;
         endcase
      endfunction

      // Called for every byte the block strobes out.
      function void check_byte(hcbp_pkg::rsp_type r);
         hcbp_pkg::rsp_type want;
         bytes_seen++;
         if (owed_bytes.size() == 0) begin
            errors++;
            $display("%0t: unexpected byte, expected none, actual %02h last %0b",
                     $time, r.packed_byte, r.last);
            return;
         end
         want = owed_bytes.pop_front();
         if (r.packed_byte !== want.packed_byte) begin
            errors++;
            $display("%0t: packed_byte mismatch, expected %02h, actual %02h",
                     $time, want.packed_byte, r.packed_byte);
         end
         if (r.last !== want.last) begin
            errors++;
            $display("%0t: last mismatch, expected %0b, actual %0b",
                     $time, want.last, r.last);
         end
      endfunction
   endclass

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              start      = 1'b0;
   hcbp_pkg::req_type req_item   = '0;
   logic              busy;
   logic              rsp_strobe;
   hcbp_pkg::rsp_type rsp_item;

   packed_byte_tracker tracker;

   // Symbols that hold a table entry; only these are ever encoded, since
   // encoding an entry that was never written is not allowed.
   bit      was_loaded [256];
   logic [7:0] loaded_syms [$];
   int      quiet_cycles = 0;

   huffman_code_bit_packer #(
      .SYMBOL_COUNT(256),
      .MAX_CODE_LEN(MAX_CODE_LEN)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item)
   );

   // 20 ns clock.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Everything is sampled at the rising edge, where the values still hold
   // what was settled during the cycle. The result is checked before the new
   // word is noted; the order does not matter since all words are in order.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) tracker.check_byte(rsp_item);
         if (start && !busy) tracker.note_word(req_item);
         // Watchdog: a long stretch with no word moving in either direction
         // means the block has hung or dropped a byte.
         if (rsp_strobe || (start && !busy)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no activity for %0d cycles, %0d bytes still owed",
                     $time, STALL_LIMIT, tracker.owed_bytes.size());
            $display("CHECK FAILED");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   function automatic hcbp_pkg::req_type make_word(hcbp_pkg::cmd_type c, logic [7:0] sym,
                                                   logic [31:0] code, logic [5:0] len);
      hcbp_pkg::req_type w;
      w.cmd         = c;
      w.symbol      = sym;
      w.code_word   = code;
      w.code_length = len;
      return w;
   endfunction

   // Holds start low, with junk on the request bus, for a span set by n.
   task automatic idle_cycles(input int n);
      repeat (n) begin
         @(negedge clock);
         start    <= 1'b0;
         req_item <= make_word(hcbp_pkg::cmd_type'($urandom_range(0, 3)), 8'($urandom),
                               $urandom, 6'($urandom));
      end
   endtask

   // Offers one word after an optional random gap and returns once it has been
   // taken. Start stays high while the block is busy; the next call changes the
   // word at the following falling edge; start drops in between only for a gap.
   task automatic send_word(input hcbp_pkg::req_type w, input int idle_pct);
      if ($urandom_range(0, 99) < idle_pct) idle_cycles($urandom_range(1, 5));
      @(negedge clock);
      start    <= 1'b1;
      req_item <= w;
      do @(posedge clock); while (busy);
      if (w.cmd == hcbp_pkg::CMD_LOAD && !was_loaded[w.symbol]) begin
         was_loaded[w.symbol] = 1'b1;
         loaded_syms.push_back(w.symbol);
      end
   endtask

   // Random traffic: mostly encodes of loaded symbols with table reloads mixed
   // in, some flushes, and an occasional unused command that does not count.
   task automatic run_random(input int count, input int idle_pct);
      int                done, pick, len;
      hcbp_pkg::req_type w;
      done = 0;
      while (done < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 24) begin
            len = $urandom_range(0, 99);
            if (len < 5)       len = 0;
            else if (len < 75) len = $urandom_range(1, 12);
            else if (len < 92) len = $urandom_range(13, 32);
            else               len = $urandom_range(33, 63);
            w = make_word(hcbp_pkg::CMD_LOAD, 8'($urandom_range(0, 255)), $urandom,
                          6'(len));
         end else if (pick < 84) begin
            w = make_word(hcbp_pkg::CMD_ENCODE,
                          loaded_syms[$urandom_range(0, loaded_syms.size() - 1)],
                          $urandom, 6'($urandom));
         end else if (pick < 96) begin
            w = make_word(hcbp_pkg::CMD_FLUSH, 8'($urandom), $urandom, 6'($urandom));
         end else begin
            w = make_word(hcbp_pkg::CMD_NONE, 8'($urandom), $urandom, 6'($urandom));
         end
         send_word(w, idle_pct);
         if (w.cmd != hcbp_pkg::CMD_NONE) done++;
      end
   endtask

   initial begin
      tracker = new();
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Directed part. A flush right after reset emits an empty byte.
      send_word(make_word(hcbp_pkg::CMD_FLUSH, 8'h00, 32'h0, 6'd0), 11);
      // Table extremes: full 32-bit code, zero length, an over-long length that
      // must saturate, a one-bit code, and a short code with junk above it.
      send_word(make_word(hcbp_pkg::CMD_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd32), 11);
      send_word(make_word(hcbp_pkg::CMD_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd0), 11);
      send_word(make_word(hcbp_pkg::CMD_LOAD, 8'h5A, 32'hA5C3_0F96, 6'd63), 11);
      send_word(make_word(hcbp_pkg::CMD_LOAD, 8'h01, 32'h0000_0001, 6'd1), 11);
      send_word(make_word(hcbp_pkg::CMD_LOAD, 8'h80, 32'hFFFF_FFF5, 6'd3), 11);
      // Byte-aligned full-length code gives four bytes.
      send_word(make_word(hcbp_pkg::CMD_ENCODE, 8'h00, 32'h0, 6'd0), 11);
      // One pending bit, then 32 more: four bytes and a bit left over.
      send_word(make_word(hcbp_pkg::CMD_ENCODE, 8'h01, 32'hFFFF_FFFF, 6'h3F), 11);
      send_word(make_word(hcbp_pkg::CMD_ENCODE, 8'h5A, 32'h0, 6'd0), 11);
      // A zero-length code adds nothing.
      send_word(make_word(hcbp_pkg::CMD_ENCODE, 8'hFF, 32'h0, 6'd0), 11);
      send_word(make_word(hcbp_pkg::CMD_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'h3F), 11);
      // Second flush with nothing pending.
      send_word(make_word(hcbp_pkg::CMD_FLUSH, 8'h00, 32'h0, 6'd0), 11);
      // The unused command must be ignored.
      send_word(make_word(hcbp_pkg::CMD_NONE, 8'h00, 32'h0, 6'd1), 11);
      // Three 3-bit codes cross a byte boundary in the middle of a code.
      send_word(make_word(hcbp_pkg::CMD_ENCODE, 8'h80, 32'h0, 6'd0), 0);
      send_word(make_word(hcbp_pkg::CMD_ENCODE, 8'h80, 32'h0, 6'd0), 0);
      send_word(make_word(hcbp_pkg::CMD_ENCODE, 8'h80, 32'h0, 6'd0), 0);
      // Two pending bits followed by a 32-bit code: the most bytes and the
      // most packing steps per symbol.
      send_word(make_word(hcbp_pkg::CMD_ENCODE, 8'h01, 32'h0, 6'd0), 0);
      send_word(make_word(hcbp_pkg::CMD_ENCODE, 8'h5A, 32'h0, 6'd0), 0);
      // Overwrite an entry with an all-zero byte-long code.
      send_word(make_word(hcbp_pkg::CMD_LOAD, 8'h01, 32'h7FFF_FF00, 6'd8), 0);
      send_word(make_word(hcbp_pkg::CMD_ENCODE, 8'h01, 32'h0, 6'd0), 0);
      send_word(make_word(hcbp_pkg::CMD_FLUSH, 8'h00, 32'h0, 6'd0), 0);
      send_word(make_word(hcbp_pkg::CMD_LOAD, 8'h80, 32'h0000_0000, 6'd33), 0);
      send_word(make_word(hcbp_pkg::CMD_ENCODE, 8'h80, 32'h0, 6'd0), 0);
      send_word(make_word(hcbp_pkg::CMD_FLUSH, 8'h00, 32'h0, 6'd0), 0);

      // Random part in three phases: light sender gaps, heavy gaps, none.
      run_random(130, 11);
      run_random(130, 48);
      run_random(125, 0);
      idle_cycles(1);

      // Drain the owed bytes (the watchdog bounds this), then give the block
      // time to show any stray byte.
      while (tracker.owed_bytes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Covered %0d loads, %0d encodes, %0d flushes and %0d ignored commands;",
               tracker.loads, tracker.encodes, tracker.flushes, tracker.ignored);
      $display("%0d packed bytes were compared, %0d errors.",
               tracker.bytes_seen, tracker.errors);
      if (tracker.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[huffman_code_bit_packer.f]
src/hcbp_pkg.sv
src/hcbp_ctrl.sv
src/hcbp_datapath.sv
src/huffman_code_bit_packer.sv
src/hcbp_checker.sv
test/tb_top.sv
